@@ design/wuf_pkg.sv @@
// Shared types and constants for the weighted union-find unit.
package wuf_pkg;

    localparam int IDX_W     = 5;
    localparam int IDX_COUNT = 32;
    localparam int SIZE_W    = 6;
    localparam int MODE_W    = 2;

    localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);
    localparam logic [SIZE_W-1:0] SIZE_SAT = SIZE_W'(63);

    localparam logic [MODE_W-1:0] MODE_UNION   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONNECT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK_A,
        S_WALK_B,
        S_LINK,
        S_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;   // request beat taken, begin walk of index_a
        logic walk;    // advance current walk by one link
        logic cap_a;   // first walk done: latch root_a, start walk of index_b
        logic cap_b;   // second walk done: latch root_b
        logic link;    // apply link and size update
        logic emit;    // load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_done;
        logic find_mode;
        logic out_free;
    } t_sts;

endpackage

@@ design/wuf_req_if.sv @@
// Request channel: mode and two element indices.
interface wuf_req_if;
    logic                             valid;
    logic                             ready;
    logic [wuf_pkg::MODE_W-1:0]       mode;
    logic [wuf_pkg::IDX_W-1:0]        index_a;
    logic [wuf_pkg::IDX_W-1:0]        index_b;

    modport source (output valid, mode, index_a, index_b, input ready);
    modport sink   (input valid, mode, index_a, index_b, output ready);
endinterface

@@ design/wuf_rsp_if.sv @@
// Response channel: roots and set flags.
interface wuf_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [wuf_pkg::IDX_W-1:0]        root_a;
    logic [wuf_pkg::IDX_W-1:0]        root_b;
    logic                             same_set;
    logic                             merged;

    modport source (output valid, root_a, root_b, same_set, merged, input ready);
    modport sink   (input valid, root_a, root_b, same_set, merged, output ready);
endinterface

@@ design/wuf_ctrl.sv @@
// Sequencer for request intake, two root walks, link update and result hand-off.
module wuf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  wuf_pkg::t_sts   i_sts,
    output logic            o_in_ready,
    output wuf_pkg::t_cmd   o_cmd
);

    wuf_pkg::t_state r_state;
    wuf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wuf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wuf_pkg::S_IDLE: begin
                if (i_in_valid) n_state = wuf_pkg::S_WALK_A;
            end
            wuf_pkg::S_WALK_A: begin
                if (i_sts.walk_done) begin
                    n_state = i_sts.find_mode ? wuf_pkg::S_EMIT : wuf_pkg::S_WALK_B;
                end
            end
            wuf_pkg::S_WALK_B: begin
                if (i_sts.walk_done) n_state = wuf_pkg::S_LINK;
            end
            wuf_pkg::S_LINK: begin
                n_state = wuf_pkg::S_EMIT;
            end
            wuf_pkg::S_EMIT: begin
                if (i_sts.out_free) n_state = wuf_pkg::S_IDLE;
            end
            default: begin
                n_state = wuf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            wuf_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            wuf_pkg::S_WALK_A: begin
                o_cmd.walk  = !i_sts.walk_done;
                o_cmd.cap_a = i_sts.walk_done;
            end
            wuf_pkg::S_WALK_B: begin
                o_cmd.walk  = !i_sts.walk_done;
                o_cmd.cap_b = i_sts.walk_done;
            end
            wuf_pkg::S_LINK: begin
                o_cmd.link = 1'b1;
            end
            wuf_pkg::S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ design/wuf_dpath.sv @@
// Parent and size tables, walk pointer, link update and result register.
module wuf_dpath #(
    parameter int NUM_ELEMENTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wuf_pkg::t_cmd                 i_cmd,
    output wuf_pkg::t_sts                 o_sts,
    input  logic [wuf_pkg::MODE_W-1:0]    i_mode,
    input  logic [wuf_pkg::IDX_W-1:0]     i_index_a,
    input  logic [wuf_pkg::IDX_W-1:0]     i_index_b,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [wuf_pkg::IDX_W-1:0]     o_root_a,
    output logic [wuf_pkg::IDX_W-1:0]     o_root_b,
    output logic                          o_same_set,
    output logic                          o_merged
);

    localparam int IW    = wuf_pkg::IDX_W;
    localparam int ZW    = wuf_pkg::SIZE_W;
    // only indices reachable through the index fields need storage
    localparam int DEPTH = (NUM_ELEMENTS < wuf_pkg::IDX_COUNT) ? NUM_ELEMENTS
                                                               : wuf_pkg::IDX_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(NUM_ELEMENTS + 1);
    localparam logic [IW:0]   DEPTH_X   = (IW + 1)'(DEPTH);
    localparam logic [SW-1:0] STEP_LIM  = SW'(NUM_ELEMENTS);

    logic [IW-1:0] r_par_mem  [DEPTH];
    logic [ZW-1:0] r_size_mem [DEPTH];
    logic [DEPTH-1:0] r_par_vld;
    logic [DEPTH-1:0] r_size_vld;

    logic [IW-1:0] r_rd_par;
    logic [ZW-1:0] r_rd_size;
    logic          r_rd_pvld;
    logic          r_rd_svld;

    logic [wuf_pkg::MODE_W-1:0] r_mode;
    logic [IW-1:0] r_b;
    logic [IW-1:0] r_cur;
    logic [SW-1:0] r_steps;
    logic [IW-1:0] r_ra;
    logic [IW-1:0] r_rb;
    logic [ZW-1:0] r_size_a;
    logic [ZW-1:0] r_size_b;

    logic          r_out_valid;
    logic [IW-1:0] r_out_root_a;
    logic [IW-1:0] r_out_root_b;
    logic          r_out_same;
    logic          r_out_merged;

    logic [IW-1:0] rd_addr;
    logic          rd_inr;
    logic [IW-1:0] par_q;
    logic [ZW-1:0] size_q;
    logic          walk_done;
    logic          is_find;
    logic          do_merge;
    logic          a_smaller;
    logic [ZW:0]   sum_w;
    logic [ZW-1:0] sum_sat;
    logic [IW-1:0] win_root;
    logic [IW-1:0] lose_root;

    // entries never written read as their reset value
    assign par_q     = r_rd_pvld ? r_rd_par  : r_cur;
    assign size_q    = r_rd_svld ? r_rd_size : wuf_pkg::SIZE_ONE;
    assign walk_done = (par_q == r_cur) || (r_steps == STEP_LIM);
    assign is_find   = (r_mode == wuf_pkg::MODE_FIND);

    always_comb begin
        if (i_cmd.start) begin
            rd_addr = i_index_a;
        end else if (i_cmd.cap_a) begin
            rd_addr = r_b;
        end else begin
            rd_addr = par_q;
        end
    end
    assign rd_inr = ({1'b0, rd_addr} < DEPTH_X);

    assign do_merge  = (r_mode == wuf_pkg::MODE_UNION) && (r_ra != r_rb)
                       && ({1'b0, r_ra} < DEPTH_X) && ({1'b0, r_rb} < DEPTH_X);
    assign a_smaller = (r_size_a < r_size_b);
    assign sum_w     = {1'b0, r_size_a} + {1'b0, r_size_b};
    assign sum_sat   = (sum_w > {1'b0, wuf_pkg::SIZE_SAT}) ? wuf_pkg::SIZE_SAT
                                                            : sum_w[ZW-1:0];
    assign win_root  = a_smaller ? r_rb : r_ra;
    assign lose_root = a_smaller ? r_ra : r_rb;

    // registered table read, one link per cycle
    always_ff @(posedge i_clk) begin
        r_rd_par  <= r_par_mem[rd_addr[AW-1:0]];
        r_rd_size <= r_size_mem[rd_addr[AW-1:0]];
        r_rd_pvld <= rd_inr && r_par_vld[rd_addr[AW-1:0]];
        r_rd_svld <= rd_inr && r_size_vld[rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.link && do_merge) begin
            r_par_mem[lose_root[AW-1:0]] <= win_root;
            r_size_mem[win_root[AW-1:0]] <= sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par_vld  <= '0;
            r_size_vld <= '0;
        end else if (i_cmd.link && do_merge) begin
            r_par_vld[lose_root[AW-1:0]] <= 1'b1;
            r_size_vld[win_root[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode  <= i_mode;
            r_b     <= i_index_b;
            r_cur   <= i_index_a;
            r_steps <= '0;
        end else if (i_cmd.walk) begin
            r_cur   <= par_q;
            r_steps <= r_steps + SW'(1);
        end else if (i_cmd.cap_a) begin
            r_ra     <= r_cur;
            r_size_a <= size_q;
            r_cur    <= r_b;
            r_steps  <= '0;
        end else if (i_cmd.cap_b) begin
            r_rb     <= r_cur;
            r_size_b <= size_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_root_a <= r_ra;
            r_out_root_b <= is_find ? '0 : r_rb;
            r_out_same   <= !is_find && (r_ra == r_rb);
            r_out_merged <= !is_find && do_merge;
        end
    end

    assign o_sts.walk_done = walk_done;
    assign o_sts.find_mode = is_find;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_root_a    = r_out_root_a;
    assign o_root_b    = r_out_root_b;
    assign o_same_set  = r_out_same;
    assign o_merged    = r_out_merged;

endmodule

@@ design/weighted_union_find_unit.sv @@
// A request walks from index_a to its root, then from index_b to its root, then applies
// the link update and loads the result; a find request skips the second walk and the link.
// Throughput: one request at a time; the next beat is taken the cycle after the result
// is loaded. The walk is bound by the parent table's registered read, one link a cycle.
// Reset clears control state and the per-entry valid bits, so every parent reads as
// itself and every size as one at once; no clearing pass.
module weighted_union_find_unit #(
    parameter int NUM_ELEMENTS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wuf_req_if.sink    i_req,
    wuf_rsp_if.source  o_rsp
);

    wuf_pkg::t_cmd w_cmd;
    wuf_pkg::t_sts w_sts;

    wuf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_in_ready (i_req.ready),
        .o_cmd      (w_cmd)
    );

    wuf_dpath #(
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_mode      (i_req.mode),
        .i_index_a   (i_req.index_a),
        .i_index_b   (i_req.index_b),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_root_a    (o_rsp.root_a),
        .o_root_b    (o_rsp.root_b),
        .o_same_set  (o_rsp.same_set),
        .o_merged    (o_rsp.merged)
    );

    // one request in flight: no beat right after a beat
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while previous one in progress");

    // link update only follows completion of the second walk
    a_link_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.link |-> $past(w_cmd.cap_b))
        else $error("link update without finished root walk");

    // a merge always joins two distinct roots
    a_merge_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.merged |-> !o_rsp.same_set && (o_rsp.root_a != o_rsp.root_b))
        else $error("merge reported for equal roots");

endmodule
